// ----- design/hlrc_pkg.sv -----
// Shared types, constants and codes of the hashed LRU reference-counted cache.
package hlrc_pkg;

    localparam int BUCKETS     = 8;
    localparam int ENTRIES     = 64;
    localparam int BKT_W       = 3;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int KEY_W       = 32;
    localparam int REF_W       = 16;
    localparam int TOTAL_W     = 32;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 96;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

    // command codes
    localparam logic [1:0] CMD_GET       = 2'd0;
    localparam logic [1:0] CMD_PUT       = 2'd1;
    localparam logic [1:0] CMD_PURGE_ONE = 2'd2;
    localparam logic [1:0] CMD_PURGE_ALL = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_USE    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_NO_ROOM   = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    // reclaim severity
    localparam logic [1:0] RECLAIM_BUCKET = 2'd0;
    localparam logic [1:0] RECLAIM_TAILS  = 2'd1;
    localparam logic [1:0] RECLAIM_ALL    = 2'd2;
    localparam logic [1:0] RECLAIM_DONE   = 2'd3;

    // one word of the entry memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REF_W-1:0] refs;
        logic [BKT_W-1:0] bucket;
        logic [IDX_W-1:0] recency;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_FRONT,
        S_TRY,
        S_FIND,
        S_UNLINK,
        S_ALLOC,
        S_HREAD,
        S_HEVAL,
        S_DONE
    } state_t;

endpackage

// ----- design/hashed_lru_refcount_cache_unit.sv -----
// Top level of the hashed LRU reference-counted cache.
//
// Usage: one command enters on the s_ stream (get, put, purge one entry,
// purge all) and exactly one result transfer leaves on the m_ stream.
// The entry_limit register is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce this.
// Entry words sit in one 64-word memory with a registered read; the valid
// bits sit in a register. The lookup, recency, find, unlink and allocation
// steps are sweeps over the memory: read, modify, write back, one entry a
// cycle. A put reads and writes back one entry; a get hit or a get miss
// with room takes a lookup sweep plus a recency sweep; each entry released
// by reclaim or purge all costs two more sweeps (find and unlink), one
// purged entry a read and an unlink sweep. One command is worked on at a
// time; the next is taken as soon as the result sits in the output register.
// Reset clears the valid bits, counters and fill levels at once; no
// memory clearing pass is needed. A stalled receiver holds the result in
// the output register; a further result waits in the done state.
module hashed_lru_refcount_cache_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], lookup_key[33:2], bucket_index[36:34], entry_handle[42:37], zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], was_miss[3], result_handle[9:4], released_count[16:10],
    // entries_in_use[23:17], peak_in_use[30:24], hit_total[62:31], miss_total[94:63], pad
    output logic [95:0] m_tdata
);

    localparam int E  = hlrc_pkg::ENTRIES;
    localparam int IW = hlrc_pkg::IDX_W;
    localparam int CW = hlrc_pkg::CNT_W;
    localparam int BW = hlrc_pkg::BKT_W;

    // entry memory
    hlrc_pkg::entry_t entry_mem [E];
    hlrc_pkg::entry_t mem_q;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    hlrc_pkg::entry_t mem_wdata;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q <= entry_mem[rd_addr];
        end
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
    end

    // control and state registers
    hlrc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic             pv_reg, pv_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      key_reg, key_next;
    logic [BW-1:0]    bkt_reg, bkt_next;
    logic [IW-1:0]    hdl_reg, hdl_next;
    logic [CW-1:0]    limit_reg;
    logic [E-1:0]     valid_reg, valid_next;
    logic [CW-1:0]    fill_reg [hlrc_pkg::BUCKETS];
    logic [CW-1:0]    fill_next [hlrc_pkg::BUCKETS];
    logic [CW-1:0]    used_reg, used_next;
    logic [CW-1:0]    peak_reg, peak_next;
    logic [31:0]      hit_total_reg, hit_total_next;
    logic [31:0]      miss_total_reg, miss_total_next;
    logic [1:0]       stage_reg, stage_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    logic [IW-1:0]    hit_rec_reg, hit_rec_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [IW-1:0]    cand_idx_reg, cand_idx_next;
    logic [BW-1:0]    cand_bkt_reg, cand_bkt_next;
    logic [IW-1:0]    cand_rec_reg, cand_rec_next;
    logic [2:0]       status_reg, status_next;
    logic             was_miss_reg, was_miss_next;
    logic [IW-1:0]    res_hdl_reg, res_hdl_next;
    logic [CW-1:0]    released_reg, released_next;
    logic             m_valid_reg, m_valid_next;
    logic [95:0]      m_data_reg, m_data_next;

    // helpers
    logic             scan_end;
    logic             dv;
    logic [CW-1:0]    lim;
    logic [BW-1:0]    fill_rd_bkt;
    logic [CW-1:0]    fill_rd;
    logic             cand_hit;

    assign scan_end    = (scan_cnt_reg == hlrc_pkg::ENTRIES_C) && !pv_reg;
    assign dv          = valid_reg[pidx_reg];
    assign lim         = (limit_reg > hlrc_pkg::ENTRIES_C) ? hlrc_pkg::ENTRIES_C : limit_reg;
    assign fill_rd_bkt = (state_reg == hlrc_pkg::S_FIND) ? mem_q.bucket : bkt_reg;
    assign fill_rd     = fill_reg[fill_rd_bkt];

    // reclaim candidate: unreferenced, and at its bucket's tail unless the sweep takes all
    always_comb begin
        cand_hit = dv && (mem_q.refs == '0);
        if (stage_reg != hlrc_pkg::RECLAIM_ALL) begin
            cand_hit = cand_hit && (({1'b0, mem_q.recency} + CW'(1)) == fill_rd);
            if (stage_reg == hlrc_pkg::RECLAIM_BUCKET) begin
                cand_hit = cand_hit && (mem_q.bucket == bkt_reg);
            end
        end
    end

    assign s_tready = (state_reg == hlrc_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // next state and datapath
    always_comb begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        bkt_next        = bkt_reg;
        hdl_next        = hdl_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        used_next       = used_reg;
        peak_next       = peak_reg;
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        stage_next      = stage_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rec_next    = hit_rec_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cand_idx_next   = cand_idx_reg;
        cand_bkt_next   = cand_bkt_reg;
        cand_rec_next   = cand_rec_reg;
        status_next     = status_reg;
        was_miss_next   = was_miss_reg;
        res_hdl_next    = res_hdl_reg;
        released_next   = released_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_cnt_reg[IW-1:0];
        mem_we          = 1'b0;
        mem_waddr       = pidx_reg;
        mem_wdata       = mem_q;

        // sweep address generator
        if ((state_reg == hlrc_pkg::S_LOOKUP) || (state_reg == hlrc_pkg::S_FRONT) ||
            (state_reg == hlrc_pkg::S_FIND) || (state_reg == hlrc_pkg::S_UNLINK) ||
            (state_reg == hlrc_pkg::S_ALLOC)) begin
            if (scan_cnt_reg != hlrc_pkg::ENTRIES_C) begin
                rd_en         = 1'b1;
                scan_cnt_next = scan_cnt_reg + CW'(1);
                pv_next       = 1'b1;
                pidx_next     = scan_cnt_reg[IW-1:0];
            end
        end

        case (state_reg)
            hlrc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_tdata[1:0];
                    key_next        = s_tdata[33:2];
                    bkt_next        = s_tdata[36:34];
                    hdl_next        = s_tdata[42:37];
                    status_next     = hlrc_pkg::ST_OK;
                    was_miss_next   = 1'b0;
                    res_hdl_next    = '0;
                    released_next   = '0;
                    stage_next      = hlrc_pkg::RECLAIM_BUCKET;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    case (s_tdata[1:0])
                        hlrc_pkg::CMD_GET:       state_next = hlrc_pkg::S_LOOKUP;
                        hlrc_pkg::CMD_PUT:       state_next = hlrc_pkg::S_HREAD;
                        hlrc_pkg::CMD_PURGE_ONE: state_next = hlrc_pkg::S_HREAD;
                        default: begin
                            stage_next = hlrc_pkg::RECLAIM_ALL;
                            state_next = hlrc_pkg::S_FIND;
                        end
                    endcase
                end
            end

            // single entry read for put and purge one entry
            hlrc_pkg::S_HREAD: begin
                rd_en      = 1'b1;
                rd_addr    = hdl_reg;
                state_next = hlrc_pkg::S_HEVAL;
            end

            hlrc_pkg::S_HEVAL: begin
                state_next = hlrc_pkg::S_DONE;
                if (cmd_reg == hlrc_pkg::CMD_PUT) begin
                    if (!valid_reg[hdl_reg]) begin
                        status_next = hlrc_pkg::ST_NOT_FOUND;
                    end else if (mem_q.refs == '0) begin
                        status_next = hlrc_pkg::ST_UNDERFLOW;
                    end else begin
                        mem_we         = 1'b1;
                        mem_waddr      = hdl_reg;
                        mem_wdata.refs = mem_q.refs - hlrc_pkg::REF_W'(1);
                    end
                end else begin
                    if (!valid_reg[hdl_reg] || (mem_q.bucket != bkt_reg)) begin
                        status_next = hlrc_pkg::ST_NOT_FOUND;
                    end else if (mem_q.refs != '0) begin
                        status_next = hlrc_pkg::ST_IN_USE;
                    end else begin
                        cand_idx_next = hdl_reg;
                        cand_bkt_next = mem_q.bucket;
                        cand_rec_next = mem_q.recency;
                        scan_cnt_next = '0;
                        state_next    = hlrc_pkg::S_UNLINK;
                    end
                end
            end

            // find the key in its bucket and note the lowest free entry
            hlrc_pkg::S_LOOKUP: begin
                if (pv_reg) begin
                    if (dv && (mem_q.bucket == bkt_reg) && (mem_q.key == key_reg) &&
                        !found_reg) begin
                        found_next   = 1'b1;
                        hit_idx_next = pidx_reg;
                        hit_rec_next = mem_q.recency;
                    end
                    if (!dv && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end
                if (scan_end) begin
                    scan_cnt_next = '0;
                    if (found_reg) begin
                        hit_total_next = hit_total_reg + 32'd1;
                        state_next     = hlrc_pkg::S_FRONT;
                    end else begin
                        state_next = hlrc_pkg::S_TRY;
                    end
                end
            end

            // hit: bump the count and move the entry to the front
            hlrc_pkg::S_FRONT: begin
                if (pv_reg && dv && (mem_q.bucket == bkt_reg)) begin
                    if (pidx_reg == hit_idx_reg) begin
                        mem_we            = 1'b1;
                        mem_wdata.recency = '0;
                        if (mem_q.refs != hlrc_pkg::REF_MAX) begin
                            mem_wdata.refs = mem_q.refs + hlrc_pkg::REF_W'(1);
                        end
                    end else if (mem_q.recency < hit_rec_reg) begin
                        mem_we            = 1'b1;
                        mem_wdata.recency = mem_q.recency + IW'(1);
                    end
                end
                if (scan_end) begin
                    res_hdl_next = hit_idx_reg;
                    state_next   = hlrc_pkg::S_DONE;
                end
            end

            // one allocation attempt, reclaim stage by stage
            hlrc_pkg::S_TRY: begin
                miss_total_next = miss_total_reg + 32'd1;
                scan_cnt_next   = '0;
                if (used_reg < lim) begin
                    state_next = hlrc_pkg::S_ALLOC;
                end else if (stage_reg != hlrc_pkg::RECLAIM_DONE) begin
                    state_next = hlrc_pkg::S_FIND;
                end else begin
                    status_next = hlrc_pkg::ST_NO_ROOM;
                    state_next  = hlrc_pkg::S_DONE;
                end
            end

            // look for the next entry to release
            hlrc_pkg::S_FIND: begin
                if (pv_reg && cand_hit) begin
                    cand_idx_next = pidx_reg;
                    cand_bkt_next = mem_q.bucket;
                    cand_rec_next = mem_q.recency;
                    scan_cnt_next = '0;
                    pv_next       = 1'b0;
                    rd_en         = 1'b0;
                    state_next    = hlrc_pkg::S_UNLINK;
                end else if (scan_end) begin
                    if (cmd_reg == hlrc_pkg::CMD_PURGE_ALL) begin
                        status_next = (used_reg != '0) ? hlrc_pkg::ST_IN_USE : hlrc_pkg::ST_OK;
                        state_next  = hlrc_pkg::S_DONE;
                    end else begin
                        stage_next = stage_reg + 2'd1;
                        state_next = hlrc_pkg::S_TRY;
                    end
                end
            end

            // close the gap left in the bucket order, then free the entry
            hlrc_pkg::S_UNLINK: begin
                if (pv_reg && dv && (mem_q.bucket == cand_bkt_reg) &&
                    (mem_q.recency > cand_rec_reg)) begin
                    mem_we            = 1'b1;
                    mem_wdata.recency = mem_q.recency - IW'(1);
                end
                if (scan_end) begin
                    valid_next[cand_idx_reg] = 1'b0;
                    for (int j = 0; j < hlrc_pkg::BUCKETS; j++) begin
                        if (cand_bkt_reg == BW'(j)) begin
                            fill_next[j] = fill_reg[j] - CW'(1);
                        end
                    end
                    used_next     = used_reg - CW'(1);
                    released_next = released_reg + CW'(1);
                    if (!free_found_reg || (cand_idx_reg < free_idx_reg)) begin
                        free_idx_next = cand_idx_reg;
                    end
                    free_found_next = 1'b1;
                    scan_cnt_next   = '0;
                    state_next      = (cmd_reg == hlrc_pkg::CMD_PURGE_ONE) ?
                                      hlrc_pkg::S_DONE : hlrc_pkg::S_FIND;
                end
            end

            // miss: push the bucket back one place, then write the new entry at the front
            hlrc_pkg::S_ALLOC: begin
                if (pv_reg && dv && (mem_q.bucket == bkt_reg)) begin
                    mem_we            = 1'b1;
                    mem_wdata.recency = mem_q.recency + IW'(1);
                end
                if (scan_end) begin
                    mem_we            = 1'b1;
                    mem_waddr         = free_idx_reg;
                    mem_wdata.key     = key_reg;
                    mem_wdata.refs    = hlrc_pkg::REF_W'(1);
                    mem_wdata.bucket  = bkt_reg;
                    mem_wdata.recency = '0;
                    valid_next[free_idx_reg] = 1'b1;
                    for (int j = 0; j < hlrc_pkg::BUCKETS; j++) begin
                        if (bkt_reg == BW'(j)) begin
                            fill_next[j] = fill_reg[j] + CW'(1);
                        end
                    end
                    used_next = used_reg + CW'(1);
                    if ((used_reg + CW'(1)) > peak_reg) begin
                        peak_next = used_reg + CW'(1);
                    end
                    was_miss_next = 1'b1;
                    res_hdl_next  = free_idx_reg;
                    state_next    = hlrc_pkg::S_DONE;
                end
            end

            // hand the result to the output register
            hlrc_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, miss_total_reg, hit_total_reg, peak_reg, used_reg,
                                    released_reg, res_hdl_reg, was_miss_reg, status_reg};
                    state_next   = hlrc_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = hlrc_pkg::S_IDLE;
            end
        endcase
    end

    // registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hlrc_pkg::S_IDLE;
            scan_cnt_reg   <= '0;
            pv_reg         <= 1'b0;
            limit_reg      <= hlrc_pkg::ENTRIES_C;
            valid_reg      <= '0;
            used_reg       <= '0;
            peak_reg       <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int j = 0; j < hlrc_pkg::BUCKETS; j++) begin
                fill_reg[j] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            pv_reg         <= pv_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            valid_reg      <= valid_next;
            used_reg       <= used_next;
            peak_reg       <= peak_next;
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
            m_valid_reg    <= m_valid_next;
            fill_reg       <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pidx_reg       <= pidx_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        bkt_reg        <= bkt_next;
        hdl_reg        <= hdl_next;
        stage_reg      <= stage_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rec_reg    <= hit_rec_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        cand_idx_reg   <= cand_idx_next;
        cand_bkt_reg   <= cand_bkt_next;
        cand_rec_reg   <= cand_rec_next;
        status_reg     <= status_next;
        was_miss_reg   <= was_miss_next;
        res_hdl_reg    <= res_hdl_next;
        released_reg   <= released_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ----- design/hlrc_checker.sv -----
// Port-level checks of the hashed LRU cache, bound to the top level.
module hlrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a stalled result transfer stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered out of reset");

    // an allocating get always succeeds
    a_miss_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> (m_tdata[2:0] == hlrc_pkg::ST_OK))
        else $error("miss flagged with failing status");

    // occupancy never above its peak or the pool size
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] <= m_tdata[30:24]) &&
                     (m_tdata[30:24] <= hlrc_pkg::ENTRIES_C))
        else $error("entries in use above peak");

    // a failed get returns no handle
    a_noroom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == hlrc_pkg::ST_NO_ROOM) |-> (m_tdata[9:4] == '0))
        else $error("handle returned on failed get");

endmodule

bind hashed_lru_refcount_cache_unit hlrc_checker u_hlrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/hashed_lru_refcount_cache_unit_tb.sv -----
// Self-checking testbench for the hashed LRU reference-counted cache unit.
`timescale 1ns / 1ps

module hashed_lru_refcount_cache_unit_tb;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    hashed_lru_refcount_cache_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    typedef struct packed {
        logic [31:0] miss_total;
        logic [31:0] hit_total;
        logic [6:0]  peak_in_use;
        logic [6:0]  entries_in_use;
        logic [6:0]  released_count;
        logic [5:0]  result_handle;
        logic        was_miss;
        logic [2:0]  status;
    } cache_resp_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [2:0]  bkt;
        logic [5:0]  hdl;
        logic        has_exp;
        logic [2:0]  exp_status;
    } cmd_row_t;

    // shadow copy of the cache state
    logic [31:0] sh_key [hlrc_pkg::ENTRIES];
    logic [15:0] sh_refs [hlrc_pkg::ENTRIES];
    logic        sh_valid [hlrc_pkg::ENTRIES];
    logic [2:0]  sh_bkt [hlrc_pkg::ENTRIES];
    logic [5:0]  sh_rec [hlrc_pkg::ENTRIES];
    int          sh_fill [hlrc_pkg::BUCKETS];
    int          sh_used, sh_peak;
    logic [31:0] sh_hits, sh_misses;
    int          sh_limit;

    cache_resp_t resp_queue[$];
    logic [2:0]  forced_status_queue[$];
    logic        forced_valid_queue[$];
    int          errors = 0;
    int          rx_count = 0;
    logic        hold_off = 0;
    logic        no_idle = 0;

    // known keys for hits
    logic [31:0] key_pool[$];
    logic [2:0]  bkt_pool[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int find_at(int b, int pos);
        for (int e = 0; e < hlrc_pkg::ENTRIES; e++)
            if (sh_valid[e] && sh_bkt[e] == b && sh_rec[e] == pos) return e;
        return -1;
    endfunction

    function automatic void drop_entry(int e);
        for (int i = 0; i < hlrc_pkg::ENTRIES; i++)
            if (sh_valid[i] && i != e && sh_bkt[i] == sh_bkt[e] && sh_rec[i] > sh_rec[e])
                sh_rec[i]--;
        if (sh_fill[sh_bkt[e]] > 0) sh_fill[sh_bkt[e]]--;
        sh_valid[e] = 0;
        sh_refs[e] = 0;
        if (sh_used > 0) sh_used--;
    endfunction

    function automatic void move_front(int e);
        for (int i = 0; i < hlrc_pkg::ENTRIES; i++)
            if (sh_valid[i] && i != e && sh_bkt[i] == sh_bkt[e] && sh_rec[i] < sh_rec[e])
                sh_rec[i]++;
        sh_rec[e] = 0;
    endfunction

    function automatic int reclaim_bucket(int b, bit stop_at_used);
        int freed, pos, e;
        freed = 0;
        pos = sh_fill[b];
        while (pos > 0) begin
            pos--;
            e = find_at(b, pos);
            if (e < 0) continue;
            if (sh_refs[e] == 0) begin
                drop_entry(e);
                freed++;
            end else if (stop_at_used) begin
                break;
            end
        end
        return freed;
    endfunction

    function automatic int reclaim(int sev, int b);
        int freed;
        freed = 0;
        if (sev == hlrc_pkg::RECLAIM_BUCKET) return reclaim_bucket(b, 1);
        for (int i = 0; i < hlrc_pkg::BUCKETS; i++)
            freed += reclaim_bucket(i, sev == hlrc_pkg::RECLAIM_TAILS);
        return freed;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < hlrc_pkg::ENTRIES; i++) begin
            sh_key[i] = '0; sh_refs[i] = '0; sh_valid[i] = 1'b0; sh_bkt[i] = '0;
            sh_rec[i] = '0;
        end
        for (int i = 0; i < hlrc_pkg::BUCKETS; i++) sh_fill[i] = 0;
        sh_used = 0; sh_peak = 0; sh_hits = '0; sh_misses = '0;
        sh_limit = hlrc_pkg::ENTRIES;
    endfunction

    // cache behavior for one command
    function automatic cache_resp_t cache_predict(logic [1:0] cmd, logic [31:0] key,
                                                  logic [2:0] b, logic [5:0] h);
        cache_resp_t r;
        int found, slot, lim, rel;
        r = '0;
        rel = 0;
        if (cmd == hlrc_pkg::CMD_GET) begin
            found = -1;
            for (int i = 0; i < hlrc_pkg::ENTRIES; i++)
                if (found < 0 && sh_valid[i] && sh_bkt[i] == b && sh_key[i] == key) found = i;
            if (found >= 0) begin
                if (sh_refs[found] != hlrc_pkg::REF_MAX) sh_refs[found]++;
                sh_hits++;
                move_front(found);
                r.result_handle = 6'(found);
            end else begin
                lim = sh_limit < hlrc_pkg::ENTRIES ? sh_limit : hlrc_pkg::ENTRIES;
                slot = -1;
                for (int sev = 0; sev < 4; sev++) begin
                    sh_misses++;
                    if (sh_used < lim) begin
                        for (int i = 0; i < hlrc_pkg::ENTRIES; i++)
                            if (slot < 0 && !sh_valid[i]) slot = i;
                        break;
                    end
                    if (sev < 3) rel += reclaim(sev, b);
                end
                if (slot >= 0) begin
                    sh_valid[slot] = 1; sh_key[slot] = key; sh_refs[slot] = 16'd1;
                    sh_bkt[slot] = b; sh_rec[slot] = 6'(sh_fill[b]);
                    sh_fill[b]++;
                    move_front(slot);
                    sh_used++;
                    if (sh_used > sh_peak) sh_peak = sh_used;
                    r.was_miss = 1;
                    r.result_handle = 6'(slot);
                end else begin
                    r.status = hlrc_pkg::ST_NO_ROOM;
                end
            end
        end else if (cmd == hlrc_pkg::CMD_PUT) begin
            if (!sh_valid[h]) r.status = hlrc_pkg::ST_NOT_FOUND;
            else if (sh_refs[h] == 0) r.status = hlrc_pkg::ST_UNDERFLOW;
            else sh_refs[h]--;
        end else if (cmd == hlrc_pkg::CMD_PURGE_ONE) begin
            if (!sh_valid[h] || sh_bkt[h] != b) r.status = hlrc_pkg::ST_NOT_FOUND;
            else if (sh_refs[h] != 0) r.status = hlrc_pkg::ST_IN_USE;
            else begin
                drop_entry(h);
                rel = 1;
            end
        end else begin
            rel = reclaim(hlrc_pkg::RECLAIM_ALL, 0);
            if (sh_used != 0) r.status = hlrc_pkg::ST_IN_USE;
        end
        r.released_count = 7'(rel);
        r.entries_in_use = 7'(sh_used);
        r.peak_in_use = 7'(sh_peak);
        r.hit_total = sh_hits;
        r.miss_total = sh_misses;
        return r;
    endfunction

    // issue one command and queue its expected result
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] key, logic [2:0] b,
                            logic [5:0] h, logic has_exp, logic [2:0] exp_st);
        cache_resp_t r;
        while (!no_idle && $urandom_range(99) < 33) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'd0, h, b, key, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = cache_predict(cmd, key, b, h);
        if (cmd == hlrc_pkg::CMD_GET && r.was_miss) begin
            key_pool.push_back(key);
            bkt_pool.push_back(b);
            if (key_pool.size() > 48) begin
                void'(key_pool.pop_front());
                void'(bkt_pool.pop_front());
            end
        end
        resp_queue.push_back(r);
        forced_valid_queue.push_back(has_exp);
        forced_status_queue.push_back(exp_st);
    endtask

    task automatic drain_then_config(logic [6:0] lim);
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (resp_queue.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sh_limit = int'(lim);
    endtask

    task automatic random_cmd();
        int k;
        logic [31:0] key;
        logic [2:0] b;
        k = $urandom_range(99);
        if (k < 35 && key_pool.size() > 0) begin
            k = $urandom_range(key_pool.size() - 1);
            send_cmd(hlrc_pkg::CMD_GET, key_pool[k], bkt_pool[k], 6'($urandom), 0, 0);
        end else if (k < 60) begin
            key = $urandom;
            b = 3'($urandom);
            send_cmd(hlrc_pkg::CMD_GET, key, b, 6'($urandom), 0, 0);
        end else if (k < 85) begin
            send_cmd(hlrc_pkg::CMD_PUT, $urandom, 3'($urandom), 6'($urandom), 0, 0);
        end else if (k < 97) begin
            b = 3'($urandom);
            send_cmd(hlrc_pkg::CMD_PURGE_ONE, $urandom, b, 6'($urandom), 0, 0);
        end else begin
            send_cmd(hlrc_pkg::CMD_PURGE_ALL, $urandom, 3'($urandom), 6'($urandom), 0, 0);
        end
    endtask

    // result receiver: random stalls plus a long hold-off window
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            m_tready <= !hold_off && (no_idle || $urandom_range(99) >= 33);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        cache_resp_t got, want;
        logic fv;
        logic [2:0] fs;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[94:0];
            rx_count++;
            if (resp_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = resp_queue.pop_front();
                fv = forced_valid_queue.pop_front();
                fs = forced_status_queue.pop_front();
                if (fv && fs != want.status) begin
                    $display("%0t: table status mismatch, expected %0d, predicted %0d",
                             $time, fs, want.status);
                    errors++;
                end
                if (got.status != want.status || got.was_miss != want.was_miss ||
                    got.result_handle != want.result_handle ||
                    got.released_count != want.released_count ||
                    got.entries_in_use != want.entries_in_use ||
                    got.peak_in_use != want.peak_in_use ||
                    got.hit_total != want.hit_total || got.miss_total != want.miss_total) begin
                    $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver hold-off, counted in cycles
    task automatic stall_receiver(int cycles);
        hold_off = 1;
        repeat (cycles) @(posedge aclk);
        hold_off = 0;
    endtask

    cmd_row_t dir_table[$];

    initial begin
        cmd_row_t row;
        reset_shadow();
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed rows
        dir_table = '{
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_NOT_FOUND},
            '{hlrc_pkg::CMD_PURGE_ONE, 32'h0,        3'd0, 6'd63, 1, hlrc_pkg::ST_NOT_FOUND},
            '{hlrc_pkg::CMD_PURGE_ALL, 32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_GET,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_GET,       32'hFFFFFFFF, 3'd7, 6'd63, 1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_GET,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PURGE_ONE, 32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_IN_USE},
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_UNDERFLOW},
            '{hlrc_pkg::CMD_PURGE_ONE, 32'h0,        3'd5, 6'd0,  1, hlrc_pkg::ST_NOT_FOUND},
            '{hlrc_pkg::CMD_PURGE_ONE, 32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_GET,       32'h12345678, 3'd7, 6'd0,  0, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PURGE_ALL, 32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_IN_USE},
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd1,  0, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PUT,       32'h0,        3'd0, 6'd0,  0, hlrc_pkg::ST_OK},
            '{hlrc_pkg::CMD_PURGE_ALL, 32'h0,        3'd0, 6'd0,  1, hlrc_pkg::ST_OK}
        };
        foreach (dir_table[i]) begin
            row = dir_table[i];
            send_cmd(row.cmd, row.key, row.bkt, row.hdl, row.has_exp, row.exp_status);
        end

        // limit 1: reclaim stages and nothing-reclaimable case
        drain_then_config(7'd1);
        send_cmd(hlrc_pkg::CMD_GET, 32'hA5A5A5A5, 3'd2, 6'd0, 0, 0);
        send_cmd(hlrc_pkg::CMD_GET, 32'h5A5A5A5A, 3'd2, 6'd0, 1, hlrc_pkg::ST_NO_ROOM);
        send_cmd(hlrc_pkg::CMD_PUT, 32'h0, 3'd0, 6'd0, 0, 0);
        send_cmd(hlrc_pkg::CMD_GET, 32'h5A5A5A5A, 3'd3, 6'd0, 1, hlrc_pkg::ST_OK);
        send_cmd(hlrc_pkg::CMD_PUT, 32'h0, 3'd0, 6'd0, 0, 0);
        send_cmd(hlrc_pkg::CMD_PURGE_ALL, 32'h0, 3'd0, 6'd0, 1, hlrc_pkg::ST_OK);

        // random phases over several limits, extremes included
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: drain_then_config(7'd4);
                1: drain_then_config(7'd64);
                2: drain_then_config(7'd127);
                3: drain_then_config(7'd12);
                4: drain_then_config(7'd1);
                default: drain_then_config(7'd40);
            endcase
            if (phase == 2) no_idle = 1;
            if (phase == 3) begin
                no_idle = 0;
                fork
                    stall_receiver(3000);
                join_none
            end
            for (int n = 0; n < 220; n++) random_cmd();
            if (phase == 1) begin
                // sender pauses until everything has come back
                s_tvalid <= 0;
                while (resp_queue.size() != 0) @(posedge aclk);
            end
        end
        no_idle = 0;

        s_tvalid <= 0;
        while (resp_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1500ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
design/hlrc_pkg.sv
design/hashed_lru_refcount_cache_unit.sv
design/hlrc_checker.sv
bench/hashed_lru_refcount_cache_unit_tb.sv
